// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text console writer: screen geometry, cell constants,
// operation codes and the control state type. No dependencies.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  // Field widths of the requests and results
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CELL_W  = 16;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ATTR_W  = 8;

  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [CELL_W-1:0] cell_t;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam attr_t             RESET_ATTR   = 8'h0F;
  localparam cell_t             RESET_BLANK  = {RESET_ATTR, BLANK_CODE};

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Control states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESP
  } state_e;

endpackage

// ----- hw/rtl/tcw_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, func, char_code, cell_index, input ready);
  modport sink   (input valid, func, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  import tcw_pkg::*;

  logic             valid;
  logic             ready;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;

  modport source (output valid, cell_value, cursor_row, cursor_col, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, output ready);
endinterface

// ----- hw/rtl/text_console_writer.sv -----
`timescale 1ns / 1ps
// Text console writer: screen memory, cursor and the sequencer for put,
// clear, read and scroll. Depends on tcw_pkg and tcw_if.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------
//  req_i    | in  | valid / ready    | func, char_code, cell_index
//  rsp_o    | out | valid / ready    | cell_value, cursor_row, cursor_col
//  cfg      | in  | cfg_we_i         | cfg_wdata_i (attribute)
//
// Put, read and unused codes pass from the request through the response state
// to the result; a put that moves below the last row adds a scroll sweep first,
// one cell copied per cycle through the single write port. Clear sweeps every
// cell of the screen. After reset a clearing pass fills the memory with blanks
// before the first request is taken. A finished result waits in the output
// register; the next request is taken meanwhile, and its result holds until
// the register is free.
module text_console_writer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  tcw_pkg::attr_t cfg_wdata_i,
  tcw_req_if.sink        req_i,
  tcw_rsp_if.source      rsp_o
);
  import tcw_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_END    = CNT_W'(CELL_COUNT);
  localparam logic [CNT_W-1:0] CNT_KEEP   = CNT_W'(CELL_COUNT - COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]   COL_END    = (COL_W + 1)'(COLUMNS);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              rd_sel_q, rd_sel_d;
  attr_t             attr_q;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             rdata_q;
  cell_t             screen_mem [CELL_COUNT];

  logic              load_out;
  logic              out_valid_q;
  cell_t             cell_value_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  logic [COL_W:0]    col_inc;
  logic [ADDR_W:0]   src_addr;
  logic [CNT_W-1:0]  dst_cnt;
  logic              wrap;
  cell_t             blank_cell;

  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign src_addr   = (ADDR_W + 1)'(cnt_q) + (ADDR_W + 1)'(COLUMNS);
  assign dst_cnt    = cnt_q - 1'b1;
  assign blank_cell = {attr_q, BLANK_CODE};
  assign wrap       = (req_i.char_code == NEWLINE_CODE) || (col_inc == COL_END);

  // Hold the attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_mem[mem_raddr];
    end
  end

  // Control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      rd_sel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      col_q    <= col_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  // Sequence requests, sweeps and memory accesses
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    col_d     = col_q;
    rd_sel_d  = rd_sel_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    req_i.ready = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = RESET_BLANK;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          rd_sel_d = 1'b0;
          cnt_d    = '0;
          state_d  = ST_RESP;
          case (req_i.func)
            FUNC_PUT: begin
              if (req_i.char_code != NEWLINE_CODE) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(row_q * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
                mem_wdata = {attr_q, req_i.char_code};
              end
              if (wrap) begin
                col_d = '0;
                if (row_q == ROW_LAST) begin
                  state_d = ST_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                col_d = col_inc[COL_W-1:0];
              end
            end
            FUNC_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              state_d = ST_CLEAR;
            end
            FUNC_READ: begin
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(req_i.cell_index);
              rd_sel_d  = (32'(req_i.cell_index) < CELL_COUNT);
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        if (32'(src_addr) < CELL_COUNT) begin
          mem_re    = 1'b1;
          mem_raddr = src_addr[ADDR_W-1:0];
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = dst_cnt[ADDR_W-1:0];
          mem_wdata = (cnt_q <= CNT_KEEP) ? rdata_q : blank_cell;
        end
        if (cnt_q == CNT_END) begin
          cnt_d   = '0;
          state_d = ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = blank_cell;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: advance on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cell_value_q <= rd_sel_q ? rdata_q : '0;
      out_row_q    <= row_q;
      out_col_q    <= col_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_value = cell_value_q;
  assign rsp_o.cursor_row = out_row_q;
  assign rsp_o.cursor_col = out_col_q;

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor left the screen");

  // A clear request starts the fill sweep
  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.func == FUNC_CLEAR)) |=> (state_q == ST_CLEAR))
    else $error("clear request did not start the fill sweep");

  // A wrap on the last row starts the scroll sweep
  a_scroll_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.func == FUNC_PUT) && wrap && (row_q == ROW_LAST))
    |=> (state_q == ST_SCROLL && row_q == ROW_LAST && col_q == '0))
    else $error("wrap on the last row did not scroll");

  // Every write stays inside the screen memory
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < CELL_COUNT))
    else $error("memory write out of range");

endmodule
